FILE: design/spk_pkg.sv
package spk_pkg;

  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ZERO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ONE  = 1'b1;

  localparam logic [WORD_W-1:0] KEY_WORD_ZERO_RST = 64'h0;
  localparam logic [WORD_W-1:0] KEY_WORD_ONE_RST  = 64'h0000_0000_d34d_b00f;

  localparam logic [COUNT_W-1:0] BLOCK_BYTES = 5'd16;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } spk_pair_t;

  typedef struct packed {
    logic [WORD_W-1:0]  x;
    logic [WORD_W-1:0]  y;
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  b;
    logic [WORD_W-1:0]  data_low;
    logic [WORD_W-1:0]  data_high;
    logic [COUNT_W-1:0] valid_bytes;
  } spk_stage_t;

  function automatic spk_pair_t spk_round(input logic [WORD_W-1:0] x,
                                          input logic [WORD_W-1:0] y,
                                          input logic [WORD_W-1:0] k);
    spk_pair_t r;
    r.x = ({x[7:0], x[WORD_W-1:8]} + y) ^ k;
    r.y = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ r.x;
    return r;
  endfunction

  function automatic logic [2*WORD_W-1:0] spk_byte_mask(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0]  nsat;
    logic [2*WORD_W-1:0] m;
    nsat = (n > BLOCK_BYTES) ? BLOCK_BYTES : n;
    for (int j = 0; j < 16; j++) begin
      m[j*8 +: 8] = (COUNT_W'(j) < nsat) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: design/spk_in_if.sv
interface spk_in_if;
  import spk_pkg::*;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  file_id;
  logic [WORD_W-1:0]  block_index;
  logic [WORD_W-1:0]  data_low;
  logic [WORD_W-1:0]  data_high;
  logic [COUNT_W-1:0] valid_bytes;

  modport source (output valid, file_id, block_index, data_low, data_high, valid_bytes,
                  input ready);
  modport sink (input valid, file_id, block_index, data_low, data_high, valid_bytes,
                output ready);
endinterface

FILE: design/spk_out_if.sv
interface spk_out_if;
  import spk_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_low;
  logic [WORD_W-1:0] out_high;

  modport source (output valid, out_low, out_high, input ready);
  modport sink (input valid, out_low, out_high, output ready);
endinterface

FILE: design/speck128_ctr_block_cipher_unit.sv
// Each round has its own pipeline register, and an output register follows the last round.
// Takes one 16-byte block per cycle while the output is not stalled; each round stage holds its item only
// while the stage after it is full and stalled, so bubbles close up under stalls.
// Synchronous active-low reset empties the pipeline and loads the key registers
// with their defaults (key word zero 0, key word one 0xd34db00f).
module speck128_ctr_block_cipher_unit
  import spk_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  spk_in_if.sink               in_ch,
  spk_out_if.source            out_ch
);

  logic [WORD_W-1:0] key_word_zero_r;
  logic [WORD_W-1:0] key_word_one_r;

  logic       stg_valid [0:ROUNDS];
  logic       stg_ready [0:ROUNDS];
  spk_stage_t stg_data  [0:ROUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word_zero_r <= KEY_WORD_ZERO_RST;
      key_word_one_r  <= KEY_WORD_ONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_WORD_ZERO: key_word_zero_r <= cfg_wdata;
        REG_KEY_WORD_ONE:  key_word_one_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    stg_valid[0]             = in_ch.valid;
    stg_data[0].x            = in_ch.block_index;
    stg_data[0].y            = in_ch.file_id;
    stg_data[0].a            = key_word_zero_r;
    stg_data[0].b            = key_word_one_r;
    stg_data[0].data_low     = in_ch.data_low;
    stg_data[0].data_high    = in_ch.data_high;
    stg_data[0].valid_bytes  = in_ch.valid_bytes;
  end

  assign in_ch.ready = stg_ready[0];

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    spk_round_stage #(
      .RND_IDX (i)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .up_data  (stg_data[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_ready[i+1]),
      .dn_data  (stg_data[i+1])
    );
  end

  spk_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_valid[ROUNDS]),
    .up_ready (stg_ready[ROUNDS]),
    .up_data  (stg_data[ROUNDS]),
    .out_ch   (out_ch)
  );

endmodule

FILE: design/spk_round_stage.sv
module spk_round_stage
  import spk_pkg::*;
#(
  parameter int RND_IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  spk_stage_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output spk_stage_t dn_data
);

  logic       valid_r;
  spk_stage_t data_r;
  spk_stage_t data_nxt;
  spk_pair_t  cipher;
  spk_pair_t  sched;
  logic       load;

  assign load     = !valid_r || dn_ready;
  assign up_ready = load;

  always_comb begin
    cipher   = spk_round(up_data.x, up_data.y, up_data.a);
    sched    = spk_round(up_data.b, up_data.a, WORD_W'(RND_IDX));
    data_nxt = up_data;
    data_nxt.x = cipher.x;
    data_nxt.y = cipher.y;
    data_nxt.b = sched.x;
    data_nxt.a = sched.y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: design/spk_out_stage.sv
module spk_out_stage
  import spk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  spk_stage_t up_data,
  spk_out_if.source  out_ch
);

  logic                valid_r;
  logic [WORD_W-1:0]   low_r;
  logic [WORD_W-1:0]   high_r;
  logic [WORD_W-1:0]   low_nxt;
  logic [WORD_W-1:0]   high_nxt;
  logic [2*WORD_W-1:0] mask;
  logic                load;

  assign load     = !valid_r || out_ch.ready;
  assign up_ready = load;

  always_comb begin
    mask     = spk_byte_mask(up_data.valid_bytes);
    low_nxt  = up_data.data_low  ^ (up_data.y & mask[WORD_W-1:0]);
    high_nxt = up_data.data_high ^ (up_data.x & mask[2*WORD_W-1:WORD_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.out_low  = low_r;
  assign out_ch.out_high = high_r;

endmodule

FILE: bench/speck128_ctr_block_cipher_unit_tb.sv
module speck128_ctr_block_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spk_pkg::*;

  localparam int CIPHER_ROUNDS  = 32;
  localparam int BLOCK_LEN      = 16;
  localparam int CLK_PERIOD     = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 200_000;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct {
    word_t              file_id;
    word_t              block_index;
    word_t              data_low;
    word_t              data_high;
    logic [COUNT_W-1:0] valid_bytes;
  } block_t;

  typedef struct {
    word_t lo;
    word_t hi;
  } cipher_out_t;

  typedef struct {
    block_t      blk;
    bit          known;
    cipher_out_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_wdata;

  spk_in_if  in_ch ();
  spk_out_if out_ch ();

  speck128_ctr_block_cipher_unit #(
    .ROUNDS(CIPHER_ROUNDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  word_t         key_zero = '0;
  word_t         key_one  = 64'h0000_0000_d34d_b00f;
  cipher_out_t   awaited_blocks[$];
  directed_row_t directed_rows[$];
  int            src_idle_pct = 0;
  int            sink_stall_pct = 0;
  int            hold_token = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  int            errors = 0;
  int            blocks_sent = 0;
  int            blocks_checked = 0;
  int            key_settings = 1;
  logic [31:0]   counts_seen = '0;

  function automatic void speck_mix(inout word_t hi, inout word_t lo, input word_t k);
    hi = (((hi >> 8) | (hi << (WORD_W - 8))) + lo) ^ k;
    lo = ((lo << 3) | (lo >> (WORD_W - 3))) ^ hi;
  endfunction

  // Encrypts the counter block and applies the keystream to the leading valid bytes.
  function automatic cipher_out_t ctr_crypt_block(block_t b, word_t k0, word_t k1);
    word_t         x;
    word_t         y;
    word_t         a;
    word_t         c;
    logic [127:0]  keep;
    int            n;
    cipher_out_t   r;
    y = b.file_id;
    x = b.block_index;
    a = k0;
    c = k1;
    for (int i = 0; i < CIPHER_ROUNDS; i++) begin
      speck_mix(x, y, a);
      speck_mix(c, a, word_t'(i));
    end
    n = (b.valid_bytes > BLOCK_LEN) ? BLOCK_LEN : int'(b.valid_bytes);
    for (int j = 0; j < BLOCK_LEN; j++) begin
      keep[j*8 +: 8] = (j < n) ? 8'hff : 8'h00;
    end
    r.lo = b.data_low ^ (y & keep[63:0]);
    r.hi = b.data_high ^ (x & keep[127:64]);
    return r;
  endfunction

  task automatic add_row(input word_t fid, input word_t idx, input word_t lo, input word_t hi,
                         input int vb, input bit known, input word_t want_lo,
                         input word_t want_hi);
    directed_row_t row;
    row.blk.file_id     = fid;
    row.blk.block_index = idx;
    row.blk.data_low    = lo;
    row.blk.data_high   = hi;
    row.blk.valid_bytes = COUNT_W'(vb);
    row.known           = known;
    row.want.lo         = want_lo;
    row.want.hi         = want_hi;
    directed_rows.push_back(row);
  endtask

  task automatic send_block(input block_t b, input bit known, input cipher_out_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.file_id     <= b.file_id;
    in_ch.block_index <= b.block_index;
    in_ch.data_low    <= b.data_low;
    in_ch.data_high   <= b.data_high;
    in_ch.valid_bytes <= b.valid_bytes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    awaited_blocks.push_back(known ? want : ctr_crypt_block(b, key_zero, key_one));
    counts_seen[b.valid_bytes] = 1'b1;
    blocks_sent++;
  endtask

  task automatic drain;
    while (awaited_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_keys(input word_t k0, input word_t k1);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_WORD_ZERO;
    cfg_wdata <= k0;
    @(posedge clk);
    cfg_index <= REG_KEY_WORD_ONE;
    cfg_wdata <= k1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    key_zero = k0;
    key_one  = k1;
    key_settings++;
  endtask

  // Most items come in runs of consecutive block indexes under one file, as a real
  // stream would; the rest are isolated blocks with arbitrary fields.
  task automatic run_phase(input word_t k0, input word_t k1, input bit load_keys,
                           input int src_pct, input int stall_pct, input int count,
                           input bit hold);
    block_t      b;
    cipher_out_t none;
    int          run_left;
    word_t       fid;
    word_t       idx;
    none = '{lo: '0, hi: '0};
    run_left = 0;
    fid = '0;
    idx = '0;
    if (load_keys) begin
      write_keys(k0, k1);
    end
    src_idle_pct = src_pct;
    sink_stall_pct <= stall_pct;
    if (hold) begin
      hold_token <= hold_token + 1;
    end
    for (int n = 0; n < count; n++) begin
      b.data_low  = {$urandom(), $urandom()};
      b.data_high = {$urandom(), $urandom()};
      if (run_left == 0 && $urandom_range(99) < 15) begin
        b.file_id     = {$urandom(), $urandom()};
        b.block_index = {$urandom(), $urandom()};
        b.valid_bytes = COUNT_W'($urandom_range(0, 31));
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 12);
          case ($urandom_range(9))
            0: fid = '0;
            1: fid = '1;
            default: fid = {$urandom(), $urandom()};
          endcase
          case ($urandom_range(9))
            0: idx = '1 - word_t'($urandom_range(5));
            1: idx = '0;
            default: idx = {$urandom(), $urandom()};
          endcase
        end
        b.file_id     = fid;
        b.block_index = idx;
        if ($urandom_range(99) < 5) begin
          b.valid_bytes = ($urandom_range(1) == 0) ? '0 : COUNT_W'($urandom_range(17, 31));
        end else if (run_left == 1 && $urandom_range(3) == 0) begin
          b.valid_bytes = COUNT_W'($urandom_range(1, 15));
        end else begin
          b.valid_bytes = COUNT_W'(BLOCK_LEN);
        end
        idx = idx + 1'b1;
        run_left--;
      end
      send_block(b, 1'b0, none);
    end
    in_ch.valid <= 1'b0;
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_token != hold_served) begin
      hold_served  <= hold_token;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_blocks.size() == 0) begin
        $error("unexpected result transfer: out_low %h out_high %h",
               out_ch.out_low, out_ch.out_high);
        errors++;
      end else begin
        want = awaited_blocks.pop_front();
        blocks_checked++;
        if (out_ch.out_low !== want.lo) begin
          $error("out_low: expected %h, actual %h", want.lo, out_ch.out_low);
          errors++;
        end
        if (out_ch.out_high !== want.hi) begin
          $error("out_high: expected %h, actual %h", want.hi, out_ch.out_high);
          errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d results outstanding.", awaited_blocks.size());
    $display("speck128_ctr_block_cipher_unit: mismatch");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_KEY_WORD_ZERO;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.file_id     <= '0;
    in_ch.block_index <= '0;
    in_ch.data_low    <= '0;
    in_ch.data_high   <= '0;
    in_ch.valid_bytes <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // A zero byte count leaves the block untouched, so those expectations are plain.
    add_row('0, '0, '0, '0, 16, 1'b0, '0, '0);
    add_row('1, '1, '1, '1, 16, 1'b0, '0, '0);
    add_row('0, '0, '1, '1, 0, 1'b1, '1, '1);
    add_row('1, '1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0, 1'b1,
            64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    add_row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, '0, '1, 0, 1'b1, '0, '1);
    add_row('1, '0, '0, '0, 16, 1'b0, '0, '0);
    add_row('0, '1, '0, '0, 16, 1'b0, '0, '0);
    add_row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
            64'haaaa_aaaa_aaaa_aaaa, 16, 1'b0, '0, '0);
    add_row(64'h1, 64'h0, '1, '1, 1, 1'b0, '0, '0);
    add_row(64'h1, 64'h1, '1, '1, 7, 1'b0, '0, '0);
    add_row(64'h1, 64'h2, '1, '1, 8, 1'b0, '0, '0);
    add_row(64'h1, 64'h3, '1, '1, 9, 1'b0, '0, '0);
    add_row(64'h1, 64'h4, '1, '1, 15, 1'b0, '0, '0);
    add_row(64'h1, 64'h5, '0, '0, 17, 1'b0, '0, '0);
    add_row(64'h1, 64'h6, '0, '0, 31, 1'b0, '0, '0);
    add_row('1, '1, '1, '1, 31, 1'b0, '0, '0);
    add_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0, '1, 24, 1'b0, '0, '0);
    add_row(64'hdead_beef_cafe_f00d, 64'h0000_0000_0000_0001, 64'h0f0f_0f0f_0f0f_0f0f,
            64'hf0f0_f0f0_f0f0_f0f0, 12, 1'b0, '0, '0);

    foreach (directed_rows[i]) begin
      send_block(directed_rows[i].blk, directed_rows[i].known, directed_rows[i].want);
    end
    in_ch.valid <= 1'b0;
    drain();

    run_phase('0, '0, 1'b0, 0, 0, 100, 1'b0);
    run_phase('0, '0, 1'b1, 71, 0, 100, 1'b0);
    run_phase('1, '1, 1'b1, 0, 71, 100, 1'b0);
    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, 1'b1, 25, 25, 100, 1'b0);
    // The output holds off while the input keeps offering at full rate, so the
    // pipeline fills and the input transfer has to stall.
    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, 1'b1, 0, 0, 120, 1'b1);
    run_phase('1, '0, 1'b1, 25, 25, 100, 1'b0);
    run_phase('0, '1, 1'b1, 0, 0, 80, 1'b0);

    repeat (CIPHER_ROUNDS + 8) @(posedge clk);
    $display("Sent %0d blocks under %0d key settings and compared %0d results.",
             blocks_sent, key_settings, blocks_checked);
    $display("Byte counts used: %0d of 32, with idle, stall and hold-off phases.",
             $countones(counts_seen));
    if (errors == 0 && awaited_blocks.size() == 0) begin
      $display("speck128_ctr_block_cipher_unit: match");
    end else begin
      $display("speck128_ctr_block_cipher_unit: mismatch");
    end
    $finish;
  end

endmodule
